// ===== src/ctbp_pkg.sv =====
// ----------------------------------------------------------------------------
// ctbp_pkg
// Shared constants and types for the code table bit packer and decoder.
// ----------------------------------------------------------------------------
package ctbp_pkg;

    localparam int TableSymbols = 256;
    localparam int LongestCode  = 32;
    localparam int SymW         = $clog2(TableSymbols);
    localparam int LenW         = 6;
    localparam int PredW        = 37;

    // operation codes
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_ENCODE = 3'd2;
    localparam logic [2:0] OP_FLUSH  = 3'd3;
    localparam logic [2:0] OP_DECODE = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_WORD  = 2'd0;
    localparam logic [1:0] KIND_FINAL = 2'd1;
    localparam logic [1:0] KIND_DEC   = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // one result beat
    typedef struct packed {
        logic [1:0]       kind;
        logic [31:0]      word;
        logic [31:0]      bits;
        logic [PredW-1:0] pred;
        logic [7:0]       sym;
        logic [LenW-1:0]  len;
        logic             found;
    } t_result;

    // low bit mask of a given length (32 and above: all ones)
    function automatic logic [31:0] low_mask(input logic [LenW-1:0] len);
        logic [31:0] m;
        begin
            if (len >= LenW'(32)) m = '1;
            else m = (32'd1 << len[4:0]) - 32'd1;
            return m;
        end
    endfunction

endpackage

// ===== src/ctbp_table.sv =====
// ----------------------------------------------------------------------------
// ctbp_table
// Code and length memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ctbp_table (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [ctbp_pkg::SymW-1:0] i_waddr,
    input  logic [7:0]               i_wcode,
    input  logic [ctbp_pkg::LenW-1:0] i_wlen,
    input  logic [ctbp_pkg::SymW-1:0] i_raddr,
    output logic [7:0]               o_rcode,
    output logic [ctbp_pkg::LenW-1:0] o_rlen
);
    logic [7+ctbp_pkg::LenW:0] r_mem [ctbp_pkg::TableSymbols];
    logic [7+ctbp_pkg::LenW:0] r_rd;

    // storage port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= {i_wlen, i_wcode};
        r_rd <= r_mem[i_raddr];
    end

    assign o_rcode = r_rd[7:0];
    assign o_rlen  = r_rd[7+ctbp_pkg::LenW:8];
endmodule

// ===== src/code_table_bit_packer_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// code_table_bit_packer_decoder_unit
// Table-driven prefix code packer: clear, load, encode, flush and decode beats.
// ----------------------------------------------------------------------------
// Encode and flush beats pass the read and execute states; an encode yields
// a result only when a word fills or its symbol has no code. A load holds
// off the next beat while its prediction sum registers; clear sweeps the
// table; decode walks it one entry a cycle to a match or the end. One beat
// in flight; ready again once any result beat is taken. Reset (synchronous,
// active low) clears the table; no beat until then; code_bits resets to 8.
module code_table_bit_packer_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,         // code_bits
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] operation, [10:3] symbol, [18:11] code_value, [42:19] frequency,
    // [74:43] code_window, [79:75] zero
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] packed_word, [63:32] stream_bits, [100:64] predicted_bits,
    // [108:101] decoded_symbol, [114:109] decoded_length, [115] match_found,
    // [119:116] zero
    output logic [119:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser         // result_kind
);
    localparam int SymW = ctbp_pkg::SymW;
    localparam int LenW = ctbp_pkg::LenW;
    localparam int PredW = ctbp_pkg::PredW;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_SCAN, S_OUT} t_state;

    t_state                  r_state;
    logic [5:0]              r_code_bits;
    logic [2:0]              r_op;
    logic [7:0]              r_sym;
    logic [23:0]             r_freq;
    logic [31:0]             r_win;
    logic [SymW:0]           r_idx;
    logic [31:0]             r_pend;
    logic [31:0]             r_bitpos;
    logic [4:0]              r_fill;
    logic [PredW-1:0]        r_pred;
    ctbp_pkg::t_result       r_res;
    logic                    r_mul_go;
    logic [LenW-1:0]         r_mul_len;

    logic                    we;
    logic [SymW-1:0]         waddr, raddr;
    logic [7:0]              wcode, rcode;
    logic [LenW-1:0]         wlen, rlen, eff_len;
    logic [31:0]             load_mask;
    logic [29:0]             prod;
    logic [PredW:0]          pred_sum;
    logic [5:0]              end_pos;
    logic [32:0]             bp_sum;
    logic [31:0]             shifted;

    ctbp_table u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wcode(wcode),
        .i_wlen (wlen),
        .i_raddr(raddr),
        .o_rcode(rcode),
        .o_rlen (rlen)
    );

    // clamped length for a load
    always_comb begin
        eff_len = r_code_bits;
        if (eff_len == '0) eff_len = LenW'(1);
        if (eff_len > LenW'(ctbp_pkg::LongestCode)) eff_len = LenW'(ctbp_pkg::LongestCode);
        if (r_freq == '0) eff_len = '0;
    end

    assign load_mask = ctbp_pkg::low_mask(eff_len);

    // memory write: clear sweep or load
    always_comb begin
        we    = 1'b0;
        waddr = r_idx[SymW-1:0];
        wcode = '0;
        wlen  = '0;
        if (r_state == S_CLEAR) begin
            we = 1'b1;
        end else if (r_state == S_EXEC && r_op == ctbp_pkg::OP_LOAD) begin
            we    = 1'b1;
            waddr = r_sym[SymW-1:0];
            wlen  = eff_len;
            wcode = r_win[7:0] & load_mask[7:0];
        end
    end

    // scan address walks, otherwise the beat's symbol
    assign raddr = (r_state == S_SCAN) ? r_idx[SymW-1:0] : r_sym[SymW-1:0];

    // one multiplier, sum registered in the cycle after the load executes
    assign prod     = 30'(r_freq) * 30'(r_mul_len);
    assign pred_sum = (PredW+1)'(r_pred) + (PredW+1)'(prod);
    assign end_pos  = 6'(r_fill) + rlen;
    assign bp_sum   = 33'(r_bitpos) + 33'(rlen);
    assign shifted  = (r_fill == '0) ? 32'd0 : (32'(rcode) >> (6'd32 - 6'(r_fill)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_code_bits <= 6'd8;
            r_pend      <= '0;
            r_bitpos    <= '0;
            r_fill      <= '0;
            r_pred      <= '0;
            r_mul_go    <= 1'b0;
        end else begin
            if (i_cfg_we) r_code_bits <= i_cfg_wdata;
            r_mul_go <= 1'b0;
            if (r_mul_go) begin
                r_pred <= pred_sum[PredW] ? '1 : pred_sum[PredW-1:0];
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + (SymW+1)'(1);
                    if (r_idx[SymW-1:0] == SymW'(ctbp_pkg::TableSymbols - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op    <= s_axis_tdata[2:0];
                        r_sym   <= s_axis_tdata[10:3];
                        r_win   <= {24'd0, s_axis_tdata[18:11]};
                        r_freq  <= s_axis_tdata[42:19];
                        r_idx   <= '0;
                        r_state <= S_READ;
                        if (s_axis_tdata[2:0] == ctbp_pkg::OP_DECODE) begin
                            r_win   <= s_axis_tdata[74:43];
                            r_state <= S_SCAN;
                        end else if (s_axis_tdata[2:0] == ctbp_pkg::OP_CLEAR) begin
                            r_state <= S_CLEAR;
                            r_pred  <= '0;
                        end
                    end
                end
                S_READ: r_state <= S_EXEC;
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_res   <= '0;
                    case (r_op)
                        ctbp_pkg::OP_LOAD: begin
                            r_mul_len <= eff_len;
                            r_mul_go  <= 1'b1;
                        end
                        ctbp_pkg::OP_ENCODE: begin
                            if (rlen == '0) begin
                                r_res.kind <= ctbp_pkg::KIND_ERR;
                                r_res.bits <= r_bitpos;
                                r_res.pred <= r_pred;
                                r_state    <= S_OUT;
                            end else begin
                                r_bitpos <= bp_sum[32] ? '1 : bp_sum[31:0];
                                r_fill   <= end_pos[4:0];
                                if (end_pos[5]) begin
                                    r_pend     <= shifted;
                                    r_res.kind <= ctbp_pkg::KIND_WORD;
                                    r_res.word <= r_pend | (32'(rcode) << r_fill);
                                    r_res.bits <= bp_sum[32] ? '1 : bp_sum[31:0];
                                    r_res.pred <= r_pred;
                                    r_state    <= S_OUT;
                                end else begin
                                    r_pend <= r_pend | (32'(rcode) << r_fill);
                                end
                            end
                        end
                        ctbp_pkg::OP_FLUSH: begin
                            r_res.kind <= ctbp_pkg::KIND_FINAL;
                            r_res.word <= r_pend;
                            r_res.bits <= r_bitpos;
                            r_res.pred <= r_pred;
                            r_pend     <= '0;
                            r_bitpos   <= '0;
                            r_fill     <= '0;
                            r_state    <= S_OUT;
                        end
                        default: ;
                    endcase
                end
                S_SCAN: begin
                    // r_idx leads read data through the registered table read
                    r_idx <= r_idx + (SymW+1)'(1);
                    if (r_idx != '0 && rlen != '0 &&
                        (r_win & ctbp_pkg::low_mask(rlen)) == 32'(rcode)) begin
                        r_res       <= '0;
                        r_res.kind  <= ctbp_pkg::KIND_DEC;
                        r_res.bits  <= r_bitpos;
                        r_res.pred  <= r_pred;
                        r_res.sym   <= 8'(r_idx - (SymW+1)'(1));
                        r_res.len   <= rlen;
                        r_res.found <= 1'b1;
                        r_state     <= S_OUT;
                    end else if (r_idx == (SymW+1)'(ctbp_pkg::TableSymbols)) begin
                        r_res      <= '0;
                        r_res.kind <= ctbp_pkg::KIND_DEC;
                        r_res.bits <= r_bitpos;
                        r_res.pred <= r_pred;
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_mul_go;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tdata  = {4'd0, r_res.found, r_res.len, r_res.sym, r_res.pred,
                            r_res.bits, r_res.word};
endmodule
